### sv/cdu_pkg.sv
// Package for the chunk stream deframer: shared types, result codes,
// register indexes and reset values. Depends on nothing.
package cdu_pkg;

    localparam int NUM_STREAMS_DEF = 64;
    localparam int FIFO_DEPTH      = 4;   // power of two
    localparam int STREAM_W        = 17;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic [16:0] CHUNK_SIZE_RST = 17'd128;
    localparam logic [31:0] ACK_WINDOW_RST = 32'd64000;
    localparam logic [23:0] MAX_LEN_RST    = 24'hFF_FFFF;
    localparam logic [31:0] EXT_TS_MARK    = 32'h00FF_FFFF;
    localparam logic [16:0] ID_BASE        = 17'd64;

    localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_WINDOW = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN    = 2'd2;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MID_MSG   = 3'd1;
    localparam logic [2:0] ERR_NOT_FMT0  = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
    localparam logic [2:0] ERR_ID_RANGE  = 3'd4;

    localparam logic [1:0] FMT_FULL  = 2'd0;
    localparam logic [1:0] FMT_CONT  = 2'd3;

    typedef struct packed {
        logic [16:0] chunk_size;
        logic [31:0] ack_window;
        logic [23:0] max_len;
    } cfg_t;

    typedef struct packed {
        logic [23:0] progress;
        logic [23:0] length;
        logic [7:0]  mtype;
        logic [31:0] msg_id;
        logic [31:0] ts;
        logic [23:0] delta;
    } row_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [16:0] chunk_stream;
        logic [7:0]  payload_byte;
        logic [7:0]  message_type;
        logic [23:0] message_length;
        logic [31:0] msg_timestamp;
        logic [31:0] message_stream;
        logic        last_of_message;
        logic [2:0]  error_code;
        logic        ack_due;
        logic [31:0] ack_count;
    } result_t;

endpackage

### sv/cdu_fifo.sv
// Small synchronous FIFO used as the front byte queue and the result queue.
// Depends on cdu_pkg.
module cdu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = cdu_pkg::FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             not_empty
);
    import cdu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign dout      = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) wptr_reg <= wptr_reg + 1'b1;
            if (do_pop) rptr_reg <= rptr_reg + 1'b1;
            if (do_push && !do_pop) count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem[wptr_reg] <= din;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fifo count over depth");
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("fifo count missed a push");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wptr_reg == rptr_reg))
        else $error("fifo pointers apart while empty");
endmodule

### sv/cdu_parser.sv
// Back end of the deframer: header parser, per-stream table memory and
// result builder. Depends on cdu_pkg.
module cdu_parser #(
    parameter int NUM_STREAMS = cdu_pkg::NUM_STREAMS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cdu_pkg::cfg_t    cfg,
    input  logic             in_valid,
    input  logic [7:0]       in_byte,
    output logic             in_pop,
    input  logic             res_room,
    output logic             res_push,
    output cdu_pkg::result_t res
);
    import cdu_pkg::*;

    localparam int IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam logic [16:0] NUM_ID = 17'(NUM_STREAMS);

    typedef enum logic [2:0] {
        PH_BASIC, PH_ID1, PH_ID2, PH_LOOKUP, PH_MHDR, PH_EXT, PH_PAYLOAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] shift_reg, shift_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [16:0] cur_reg, cur_next;
    logic [16:0] rem_reg, rem_next;
    row_t        wc_reg, wc_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] win_reg, win_next;
    logic        halted_reg, halted_next;

    // stream table
    row_t                   mem [NUM_STREAMS];
    logic [NUM_STREAMS-1:0] row_valid_reg;
    row_t                   rd_row_reg;
    logic                   rd_valid_reg;
    logic                   rd_en, mem_we, set_valid;

    // scratch
    logic        id_done, hd_go, bp_go, fail_go, ack_req;
    logic [2:0]  fail_code;
    row_t        hd_row, bp_row, wc_upd, look_row;
    logic [31:0] sh;
    logic [3:0]  n, hlen;
    logic [23:0] left;
    logic [23:0] cs24;
    logic [23:0] prog_n;
    logic [16:0] rem_n;
    logic        last_b;

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        fmt_next    = fmt_reg;
        cur_next    = cur_reg;
        rem_next    = rem_reg;
        wc_next     = wc_reg;
        total_next  = total_reg;
        win_next    = win_reg;
        halted_next = halted_reg;
        rd_en = 1'b0; mem_we = 1'b0; set_valid = 1'b0;
        in_pop = 1'b0; res_push = 1'b0; res = '0;
        id_done = 1'b0; hd_go = 1'b0; bp_go = 1'b0; fail_go = 1'b0; ack_req = 1'b0;
        fail_code = ERR_NONE;
        hd_row = wc_reg; bp_row = wc_reg; wc_upd = wc_reg;
        look_row = rd_valid_reg ? rd_row_reg : '0;
        sh = {shift_reg[23:0], in_byte};
        n = cnt_reg + 1'b1;
        case (fmt_reg)
            2'd0:    hlen = 4'd11;
            2'd1:    hlen = 4'd7;
            2'd2:    hlen = 4'd3;
            default: hlen = 4'd0;
        endcase
        left = '0; cs24 = '0; prog_n = '0; rem_n = '0; last_b = 1'b0;

        if (in_valid && res_room && phase_reg != PH_LOOKUP) begin
            in_pop = 1'b1;
            if (!halted_reg) begin
                total_next = total_reg + 1'b1;
                if (win_reg != '1) win_next = win_reg + 1'b1;
                case (phase_reg)
                    PH_BASIC: begin
                        fmt_next = in_byte[7:6];
                        if (in_byte[5:1] == '0) begin
                            cur_next   = ID_BASE;
                            phase_next = in_byte[0] ? PH_ID1 : PH_ID2;
                        end else begin
                            cur_next = {11'b0, in_byte[5:0]};
                            id_done  = 1'b1;
                        end
                    end
                    PH_ID1: begin
                        cur_next   = ID_BASE + {9'b0, in_byte};
                        phase_next = PH_ID2;
                        cnt_next   = 4'd1;
                    end
                    PH_ID2: begin
                        cur_next = (cnt_reg == 4'd1) ? cur_reg + {1'b0, in_byte, 8'b0}
                                                     : cur_reg + {9'b0, in_byte};
                        cnt_next = '0;
                        id_done  = 1'b1;
                    end
                    PH_MHDR: begin
                        shift_next = sh;
                        cnt_next   = n;
                        case (n)
                            4'd3: begin
                                if (fmt_reg == FMT_FULL) begin
                                    wc_upd.ts    = {8'b0, sh[23:0]};
                                    wc_upd.delta = '0;
                                end else begin
                                    wc_upd.delta = sh[23:0];
                                end
                                shift_next = '0;
                            end
                            4'd6: begin
                                wc_upd.length = sh[23:0];
                                shift_next = '0;
                            end
                            4'd7: begin
                                wc_upd.mtype = sh[7:0];
                                shift_next = '0;
                            end
                            4'd11: begin
                                wc_upd.msg_id = sh;
                                shift_next = '0;
                            end
                            default: ;
                        endcase
                        wc_next = wc_upd;
                        mem_we  = 1'b1;
                        if (n >= hlen) begin
                            hd_go  = 1'b1;
                            hd_row = wc_upd;
                        end
                    end
                    PH_EXT: begin
                        shift_next = sh;
                        cnt_next   = n;
                        if (n >= 4'd4) begin
                            wc_upd.ts  = sh;
                            wc_next    = wc_upd;
                            mem_we     = 1'b1;
                            shift_next = '0;
                            cnt_next   = '0;
                            bp_go      = 1'b1;
                            bp_row     = wc_upd;
                        end
                    end
                    PH_PAYLOAD: begin
                        prog_n = wc_reg.progress + 1'b1;
                        rem_n  = rem_reg - 1'b1;
                        last_b = (prog_n >= wc_reg.length);
                        rem_next = rem_n;
                        wc_upd.progress = prog_n;
                        if (rem_n == '0 || last_b) begin
                            rem_next   = '0;
                            phase_next = PH_BASIC;
                            ack_req    = 1'b1;
                        end
                        res_push             = 1'b1;
                        res.kind             = KIND_PAYLOAD;
                        res.payload_byte     = in_byte;
                        res.message_type     = wc_reg.mtype;
                        res.message_length   = wc_reg.length;
                        res.msg_timestamp    = wc_reg.ts;
                        res.message_stream   = wc_reg.msg_id;
                        res.last_of_message  = last_b;
                        if (last_b) begin
                            wc_upd.ts       = wc_reg.ts + {8'b0, wc_reg.delta};
                            wc_upd.progress = '0;
                        end
                        wc_next = wc_upd;
                        mem_we  = 1'b1;
                    end
                    default: phase_next = PH_BASIC;
                endcase
                if (id_done) begin
                    if (cur_next >= NUM_ID) begin
                        fail_go   = 1'b1;
                        fail_code = ERR_ID_RANGE;
                    end else begin
                        rd_en      = 1'b1;
                        phase_next = PH_LOOKUP;
                    end
                end
            end
        end else if (phase_reg == PH_LOOKUP && res_room) begin
            if (fmt_reg != FMT_CONT && look_row.progress != '0) begin
                fail_go   = 1'b1;
                fail_code = ERR_MID_MSG;
            end else if (!rd_valid_reg && fmt_reg != FMT_FULL) begin
                fail_go   = 1'b1;
                fail_code = ERR_NOT_FMT0;
            end else begin
                set_valid  = 1'b1;
                mem_we     = 1'b1;
                wc_next    = look_row;
                cnt_next   = '0;
                shift_next = '0;
                if (fmt_reg == FMT_CONT) begin
                    hd_go  = 1'b1;
                    hd_row = look_row;
                end else begin
                    phase_next = PH_MHDR;
                end
            end
        end

        // header complete: extended timestamp or payload
        if (hd_go) begin
            if (hd_row.ts >= EXT_TS_MARK) begin
                phase_next = PH_EXT;
                cnt_next   = '0;
                shift_next = '0;
            end else begin
                bp_go  = 1'b1;
                bp_row = hd_row;
            end
        end

        // start of payload: length check, then empty completion or payload phase
        if (bp_go) begin
            if (bp_row.length > cfg.max_len) begin
                fail_go   = 1'b1;
                fail_code = ERR_TOO_LONG;
            end else begin
                left = (bp_row.length > bp_row.progress) ? bp_row.length - bp_row.progress
                                                         : '0;
                cs24 = (cfg.chunk_size == '0) ? 24'd1 : {7'b0, cfg.chunk_size};
                if (left > cs24) left = cs24;
                if (left == '0) begin
                    ack_req             = 1'b1;
                    res_push            = 1'b1;
                    res.kind            = KIND_EMPTY;
                    res.message_type    = bp_row.mtype;
                    res.message_length  = bp_row.length;
                    res.msg_timestamp   = bp_row.ts;
                    res.message_stream  = bp_row.msg_id;
                    res.last_of_message = 1'b1;
                    wc_upd          = bp_row;
                    wc_upd.ts       = bp_row.ts + {8'b0, bp_row.delta};
                    wc_upd.progress = '0;
                    wc_next         = wc_upd;
                    mem_we          = 1'b1;
                    phase_next      = PH_BASIC;
                end else begin
                    rem_next   = left[16:0];
                    phase_next = PH_PAYLOAD;
                end
            end
        end

        if (ack_req && !fail_go && cfg.ack_window != '0 && win_next >= cfg.ack_window) begin
            win_next    = '0;
            res.ack_due = 1'b1;
        end

        if (fail_go) begin
            halted_next    = 1'b1;
            phase_next     = PH_BASIC;
            res_push       = 1'b1;
            res            = '0;
            res.kind       = KIND_ERROR;
            res.error_code = fail_code;
        end

        res.chunk_stream = cur_next;
        res.ack_count    = total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_BASIC;
            cnt_reg       <= '0;
            shift_reg     <= '0;
            fmt_reg       <= '0;
            cur_reg       <= '0;
            rem_reg       <= '0;
            total_reg     <= '0;
            win_reg       <= '0;
            halted_reg    <= 1'b0;
            row_valid_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            shift_reg  <= shift_next;
            fmt_reg    <= fmt_next;
            cur_reg    <= cur_next;
            rem_reg    <= rem_next;
            total_reg  <= total_next;
            win_reg    <= win_next;
            halted_reg <= halted_next;
            if (set_valid) row_valid_reg[cur_reg[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        wc_reg <= wc_next;
        if (mem_we) mem[cur_reg[IDX_W-1:0]] <= wc_next;
        if (rd_en) begin
            rd_row_reg   <= mem[cur_next[IDX_W-1:0]];
            rd_valid_reg <= row_valid_reg[cur_next[IDX_W-1:0]];
        end
    end

    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");
    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_push && res.kind == KIND_ERROR) |=> halted_reg)
        else $error("error result without halt");
    a_payload_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (rem_reg != '0))
        else $error("payload phase with no bytes left in chunk");
endmodule

### sv/chunk_stream_deframer_unit.sv
// Top level of the chunk stream deframer: byte queue, parser and result queue.
// Depends on cdu_pkg, cdu_fifo and cdu_parser.
//
// Usage:
//  - Input channel s_valid/s_ready carries one received byte per transaction
//    (s_rx_byte). Bytes go into a short front queue.
//  - The parser takes one byte per cycle while the result queue has room.
//    When a chunk basic header completes, it stops taking bytes in a lookup
//    state while it reads the stream table (registered memory read).
//  - Output channel m_valid/m_ready carries at most one result per byte:
//    payload bytes, empty-message completions and errors. A byte passes the
//    byte queue, then the parser into the result queue, with a stream table
//    read first after a basic header.
//  - If the receiver stalls, the result queue fills, the parser stops and the
//    byte queue then deasserts s_ready. Nothing is dropped.
//  - An error result halts the parser: later bytes are taken and dropped
//    until reset. aresetn (synchronous, active low) clears the parser, the
//    queues and the table valid bits, and loads register defaults.
//  - Configuration: cfg_wr_en/cfg_index/cfg_wr_data write chunk_size,
//    ack_window and max_message_len; write only while the block is idle.
module chunk_stream_deframer_unit #(
    parameter int NUM_STREAMS = cdu_pkg::NUM_STREAMS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [cdu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cdu_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_kind,
    output logic [16:0]                      m_chunk_stream,
    output logic [7:0]                       m_payload_byte,
    output logic [7:0]                       m_message_type,
    output logic [23:0]                      m_message_length,
    output logic [31:0]                      m_msg_timestamp,
    output logic [31:0]                      m_message_stream,
    output logic                             m_last_of_message,
    output logic [2:0]                       m_error_code,
    output logic                             m_ack_due,
    output logic [31:0]                      m_ack_count
);
    import cdu_pkg::*;

    // configuration registers
    logic [16:0] chunk_size_reg;
    logic [31:0] ack_window_reg;
    logic [23:0] max_len_reg;
    cfg_t        cfg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_size_reg <= CHUNK_SIZE_RST;
            ack_window_reg <= ACK_WINDOW_RST;
            max_len_reg    <= MAX_LEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CHUNK_SIZE: chunk_size_reg <= cfg_wr_data[16:0];
                REG_ACK_WINDOW: ack_window_reg <= cfg_wr_data;
                REG_MAX_LEN:    max_len_reg    <= cfg_wr_data[23:0];
                default: ;  // unused index, ignored
            endcase
        end
    end

    assign cfg = '{chunk_size: chunk_size_reg, ack_window: ack_window_reg,
                   max_len: max_len_reg};

    // front: byte queue
    logic       in_full, in_pop, in_avail;
    logic [7:0] in_byte;

    cdu_fifo #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_in_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .din       (s_rx_byte),
        .full      (in_full),
        .pop       (in_pop),
        .dout      (in_byte),
        .not_empty (in_avail)
    );
    assign s_ready = !in_full;

    // back: parser
    logic    res_push, res_full;
    result_t res, out_res;

    cdu_parser #(.NUM_STREAMS(NUM_STREAMS)) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (in_avail),
        .in_byte  (in_byte),
        .in_pop   (in_pop),
        .res_room (!res_full),
        .res_push (res_push),
        .res      (res)
    );

    // result queue decouples the parser from receiver stalls
    cdu_fifo #(.WIDTH($bits(result_t)), .DEPTH(FIFO_DEPTH)) u_out_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .din       (res),
        .full      (res_full),
        .pop       (m_ready),
        .dout      (out_res),
        .not_empty (m_valid)
    );

    assign m_kind            = out_res.kind;
    assign m_chunk_stream    = out_res.chunk_stream;
    assign m_payload_byte    = out_res.payload_byte;
    assign m_message_type    = out_res.message_type;
    assign m_message_length  = out_res.message_length;
    assign m_msg_timestamp   = out_res.msg_timestamp;
    assign m_message_stream  = out_res.message_stream;
    assign m_last_of_message = out_res.last_of_message;
    assign m_error_code      = out_res.error_code;
    assign m_ack_due         = out_res.ack_due;
    assign m_ack_count       = out_res.ack_count;
endmodule

### sim/tb_chunk_stream_deframer_unit.sv
// Self-checking testbench for chunk_stream_deframer_unit: directed chunk table, then
// random well-formed chunk traffic over several register settings, then one protocol error.
// Depends on cdu_pkg and the RTL of the deframer.
module tb_chunk_stream_deframer_unit;
    import cdu_pkg::*;

    localparam int NS         = 64;
    localparam int IDLE_LIMIT = 4000;   // cycles with no transaction at all
    localparam int PHASE_LEN  = 200;    // random bytes per register setting

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [16:0] m_chunk_stream;
    logic [7:0]  m_payload_byte;
    logic [7:0]  m_message_type;
    logic [23:0] m_message_length;
    logic [31:0] m_msg_timestamp;
    logic [31:0] m_message_stream;
    logic        m_last_of_message;
    logic [2:0]  m_error_code;
    logic        m_ack_due;
    logic [31:0] m_ack_count;

    always #10 aclk = ~aclk;

    chunk_stream_deframer_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_chunk_stream   (m_chunk_stream),
        .m_payload_byte   (m_payload_byte),
        .m_message_type   (m_message_type),
        .m_message_length (m_message_length),
        .m_msg_timestamp  (m_msg_timestamp),
        .m_message_stream (m_message_stream),
        .m_last_of_message(m_last_of_message),
        .m_error_code     (m_error_code),
        .m_ack_due        (m_ack_due),
        .m_ack_count      (m_ack_count)
    );

    // ------------------------------------------------------------------
    // Deframer predictor state: parser, per-stream table, counters.
    // ------------------------------------------------------------------
    typedef enum logic [2:0] {ST_BASIC, ST_ID1, ST_ID2, ST_HDR, ST_EXT, ST_BODY} parse_st_t;

    logic [16:0] p_chunk_size = CHUNK_SIZE_RST;
    logic [31:0] p_ack_window = ACK_WINDOW_RST;
    logic [23:0] p_max_len    = MAX_LEN_RST;

    parse_st_t   phase = ST_BASIC;
    int unsigned hcnt = 0;
    logic [31:0] hshift = '0;
    logic [1:0]  fmt = '0;
    logic [16:0] cs_id = '0;
    logic [16:0] crem = '0;
    bit          sv_valid [NS];
    logic [23:0] sv_prog  [NS];
    logic [23:0] sv_len   [NS];
    logic [7:0]  sv_type  [NS];
    logic [31:0] sv_msgid [NS];
    logic [31:0] sv_time  [NS];
    logic [23:0] sv_delta [NS];
    logic [31:0] total_rx = '0;
    logic [31:0] window_rx = '0;
    bit          stopped = 1'b0;

    result_t pending_results [$];
    int      fails = 0;
    int      bytes_sent = 0;
    bit      calm = 1'b0;        // no idling on either side while set

    initial begin
        for (int i = 0; i < NS; i++) begin
            sv_valid[i] = 1'b0; sv_prog[i] = '0; sv_len[i] = '0; sv_type[i] = '0;
            sv_msgid[i] = '0; sv_time[i] = '0; sv_delta[i] = '0;
        end
    end

    function automatic void emit(logic [1:0] kind, logic [7:0] b, bit last,
                                 logic [2:0] err, bit ack);
        result_t r;
        bit fill;
        fill = (kind != KIND_ERROR) && (cs_id < NS);
        r.kind            = kind;
        r.chunk_stream    = cs_id;
        r.payload_byte    = b;
        r.message_type    = fill ? sv_type[cs_id]  : '0;
        r.message_length  = fill ? sv_len[cs_id]   : '0;
        r.msg_timestamp   = fill ? sv_time[cs_id]  : '0;
        r.message_stream  = fill ? sv_msgid[cs_id] : '0;
        r.last_of_message = last;
        r.error_code      = err;
        r.ack_due         = ack;
        r.ack_count       = total_rx;
        pending_results.push_back(r);
    endfunction

    function automatic void halt_on(logic [2:0] code);
        stopped = 1'b1;
        phase = ST_BASIC;
        emit(KIND_ERROR, '0, 1'b0, code, 1'b0);
    endfunction

    // ACK is due only at a chunk end, and clears the window count
    function automatic bit ack_hit();
        if (p_ack_window != 0 && window_rx >= p_ack_window) begin
            window_rx = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int unsigned hdr_len(logic [1:0] f);
        case (f)
            2'd0: return 11;
            2'd1: return 7;
            2'd2: return 3;
            default: return 0;
        endcase
    endfunction

    function automatic void start_body();
        logic [23:0] left;
        logic [23:0] csz;
        if (sv_len[cs_id] > p_max_len) begin
            halt_on(ERR_TOO_LONG);
            return;
        end
        left = (sv_len[cs_id] > sv_prog[cs_id]) ? sv_len[cs_id] - sv_prog[cs_id] : '0;
        csz = (p_chunk_size == 0) ? 24'd1 : 24'(p_chunk_size);
        if (left > csz) left = csz;
        if (left == 0) begin
            // zero-length message: completion result, delta applied
            emit(KIND_EMPTY, '0, 1'b1, ERR_NONE, ack_hit());
            sv_time[cs_id] = sv_time[cs_id] + 32'(sv_delta[cs_id]);
            sv_prog[cs_id] = '0;
            phase = ST_BASIC;
        end else begin
            crem = left[16:0];
            phase = ST_BODY;
        end
    endfunction

    function automatic void hdr_done();
        if (sv_time[cs_id] >= EXT_TS_MARK) begin
            phase = ST_EXT;
            hcnt = 0;
            hshift = '0;
        end else begin
            start_body();
        end
    endfunction

    // basic header complete: range, mid-message and first-chunk checks in that order
    function automatic void basic_done();
        if (cs_id >= NS) halt_on(ERR_ID_RANGE);
        else if (fmt != FMT_CONT && sv_prog[cs_id] != 0) halt_on(ERR_MID_MSG);
        else if (!sv_valid[cs_id] && fmt != FMT_FULL) halt_on(ERR_NOT_FMT0);
        else begin
            sv_valid[cs_id] = 1'b1;
            hcnt = 0;
            hshift = '0;
            if (hdr_len(fmt) == 0) hdr_done();
            else phase = ST_HDR;
        end
    endfunction

    function automatic void track_byte(logic [7:0] b);
        bit last;
        bit ack;
        if (stopped) return;
        total_rx = total_rx + 1;
        if (window_rx != 32'hFFFF_FFFF) window_rx = window_rx + 1;
        case (phase)
            ST_BASIC: begin
                fmt = b[7:6];
                if (b[5:0] <= 6'd1) begin
                    cs_id = ID_BASE;
                    phase = (b[5:0] == 6'd0) ? ST_ID2 : ST_ID1;
                end else begin
                    cs_id = 17'(b[5:0]);
                    basic_done();
                end
            end
            ST_ID1: begin
                cs_id = ID_BASE + 17'(b);
                phase = ST_ID2;
                hcnt = 1;
            end
            ST_ID2: begin
                cs_id = cs_id + ((hcnt == 1) ? 17'(b) * 17'd256 : 17'(b));
                hcnt = 0;
                basic_done();
            end
            ST_HDR: begin
                hshift = {hshift[23:0], b};
                hcnt++;
                case (hcnt)
                    3: begin
                        if (fmt == FMT_FULL) begin
                            sv_time[cs_id] = {8'd0, hshift[23:0]};
                            sv_delta[cs_id] = '0;
                        end else begin
                            sv_delta[cs_id] = hshift[23:0];
                        end
                        hshift = '0;
                    end
                    6: begin sv_len[cs_id] = hshift[23:0]; hshift = '0; end
                    7: begin sv_type[cs_id] = hshift[7:0]; hshift = '0; end
                    11: begin sv_msgid[cs_id] = hshift; hshift = '0; end
                    default: ;
                endcase
                if (hcnt >= hdr_len(fmt)) hdr_done();
            end
            ST_EXT: begin
                hshift = {hshift[23:0], b};
                hcnt++;
                if (hcnt >= 4) begin
                    sv_time[cs_id] = hshift;
                    hshift = '0;
                    hcnt = 0;
                    start_body();
                end
            end
            ST_BODY: begin
                sv_prog[cs_id] = sv_prog[cs_id] + 24'd1;
                crem = crem - 17'd1;
                last = sv_prog[cs_id] >= sv_len[cs_id];
                ack = 1'b0;
                if (crem == 0 || last) begin
                    crem = '0;
                    phase = ST_BASIC;
                    ack = ack_hit();
                end
                emit(KIND_PAYLOAD, b, last, ERR_NONE, ack);
                if (last) begin
                    sv_time[cs_id] = sv_time[cs_id] + 32'(sv_delta[cs_id]);
                    sv_prog[cs_id] = '0;
                end
            end
            default: phase = ST_BASIC;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side. Valid stays high between back-to-back transactions; it
    // drops only in an idle cycle or before a pause.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        track_byte(b);
        bytes_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    // wait for every result in flight, then for the parser latency
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // all three registers in one burst; enable drops once at the end
    task automatic set_config(input logic [16:0] csz, input logic [31:0] aw,
                              input logic [23:0] ml);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_CHUNK_SIZE; cfg_wr_data <= 32'(csz); @(posedge aclk);
        cfg_index <= REG_ACK_WINDOW; cfg_wr_data <= aw;       @(posedge aclk);
        cfg_index <= REG_MAX_LEN;    cfg_wr_data <= 32'(ml);  @(posedge aclk);
        cfg_wr_en <= 1'b0;
        p_chunk_size = csz;
        p_ack_window = aw;
        p_max_len    = ml;
    endtask

    function automatic bit any_open();
        for (int i = 0; i < NS; i++)
            if (sv_prog[i] != 0) return 1'b1;
        return 1'b0;
    endfunction

    task automatic send_hdr0(input logic [5:0] s, input logic [23:0] ln);
        send_byte({FMT_FULL, s});
        repeat (3) send_byte(8'h00);
        send_byte(ln[23:16]); send_byte(ln[15:8]); send_byte(ln[7:0]);
        repeat (5) send_byte(8'($urandom));
    endtask

    // One well-formed chunk with random content. When closing out a phase,
    // only streams with a message in progress are continued.
    task automatic send_chunk(input bit closing);
        logic [5:0]  s;
        logic [1:0]  f;
        logic [23:0] ts;
        logic [23:0] ln;
        logic [7:0]  typ;
        logic [31:0] mid;
        int unsigned r;
        s = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(2, 62) : $urandom_range(2, 5));
        if (closing) begin
            for (int i = NS - 1; i >= 2; i--)
                if (sv_prog[i] != 0) s = 6'(i);
        end
        if (sv_prog[s] != 0) f = FMT_CONT;
        else if (!sv_valid[s]) f = FMT_FULL;
        else f = 2'($urandom_range(0, 3));
        // a stored length past the current limit needs a fresh one
        if (f >= 2'd2 && sv_prog[s] == 0 && sv_len[s] > p_max_len) f = 2'd1;
        ts = ($urandom_range(0, 7) == 0) ? 24'hFF_FFFF : 24'($urandom);
        r = $urandom_range(0, 15);
        if (r == 0) ln = '0;
        else if (r < 12) ln = 24'($urandom_range(1, 24));
        else if (r < 15) ln = 24'($urandom_range(25, 300));
        else ln = 24'($urandom_range(301, 2000));
        if (ln > p_max_len) ln = 24'($urandom_range(0, p_max_len));
        typ = 8'($urandom);
        mid = $urandom;
        send_byte({f, s});
        if (f != FMT_CONT) begin
            send_byte(ts[23:16]); send_byte(ts[15:8]); send_byte(ts[7:0]);
        end
        if (f <= 2'd1) begin
            send_byte(ln[23:16]); send_byte(ln[15:8]); send_byte(ln[7:0]);
            send_byte(typ);
        end
        if (f == FMT_FULL) begin
            send_byte(mid[31:24]); send_byte(mid[23:16]);
            send_byte(mid[15:8]);  send_byte(mid[7:0]);
        end
        // extended timestamp and payload bytes
        while (phase != ST_BASIC) send_byte(8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, compare each transaction with the oldest
    // predicted result.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0h got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t e;
        m_ready <= calm || ($urandom_range(0, 99) >= 38);
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no prediction pending, kind %0d", m_kind);
                fails++;
            end else begin
                e = pending_results.pop_front();
                check_field("kind",            32'(e.kind),            32'(m_kind));
                check_field("chunk_stream",    32'(e.chunk_stream),    32'(m_chunk_stream));
                check_field("payload_byte",    32'(e.payload_byte),    32'(m_payload_byte));
                check_field("message_type",    32'(e.message_type),    32'(m_message_type));
                check_field("message_length",  32'(e.message_length),  32'(m_message_length));
                check_field("msg_timestamp",   e.msg_timestamp,        m_msg_timestamp);
                check_field("message_stream",  e.message_stream,       m_message_stream);
                check_field("last_of_message", 32'(e.last_of_message), 32'(m_last_of_message));
                check_field("error_code",      32'(e.error_code),      32'(m_error_code));
                check_field("ack_due",         32'(e.ack_due),         32'(m_ack_due));
                check_field("ack_count",       e.ack_count,            m_ack_count);
            end
        end
    end

    // watchdog: too long without any transaction means a hang
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("FAIL chunk_stream_deframer_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table, at reset register values. Typed rows carry the
    // result kind and end-of-message flag that are plain from the bytes.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0] b;
        bit         typed;
        logic [1:0] kind;
        bit         last;
    } stim_row_t;

    localparam int N_ROWS = 27;
    stim_row_t stim_rows [N_ROWS] = '{
        // full header on stream 2: ts 5, length 1, type 0x14, stream id FF00A55A
        '{8'h02, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h00, 1'b0, KIND_PAYLOAD, 1'b0}, '{8'h00, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h05, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h00, 1'b0, KIND_PAYLOAD, 1'b0}, '{8'h00, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h01, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h14, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'hFF, 1'b0, KIND_PAYLOAD, 1'b0}, '{8'h00, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'hA5, 1'b0, KIND_PAYLOAD, 1'b0}, '{8'h5A, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'hFF, 1'b1, KIND_PAYLOAD, 1'b1},
        // continuation header on an idle stream reopens the stored message
        '{8'hC2, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h00, 1'b1, KIND_PAYLOAD, 1'b1},
        // format 1, delta 3, zero length: empty completion
        '{8'h42, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h00, 1'b0, KIND_PAYLOAD, 1'b0}, '{8'h00, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h03, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h00, 1'b0, KIND_PAYLOAD, 1'b0}, '{8'h00, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h00, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'h09, 1'b1, KIND_EMPTY, 1'b1},
        // format 2 with max delta: timestamp climbs into extended range
        '{8'h82, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'hFF, 1'b0, KIND_PAYLOAD, 1'b0}, '{8'hFF, 1'b0, KIND_PAYLOAD, 1'b0},
        '{8'hFF, 1'b1, KIND_EMPTY, 1'b1}
    };

    typedef struct packed {
        logic [16:0] csz;
        logic [31:0] aw;
        logic [23:0] ml;
    } reg_set_t;

    localparam int N_SETS = 6;
    reg_set_t reg_sets [N_SETS] = '{
        '{17'd1,       32'd0,          24'hFF_FFFF},
        '{17'h1_0000,  32'hFFFF_FFFF,  24'd300},
        '{17'd0,       32'd50,         24'd0},       // zero chunk size acts as one
        '{17'd7,       32'd200,        24'hFF_FFFF}, // run without idling
        '{17'd64,      32'd1000,       24'd2000},
        '{17'd3,       32'd1,          24'd64}
    };

    initial begin
        int          start;
        int unsigned pick;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i]) begin
            send_byte(stim_rows[i].b);
            if (stim_rows[i].typed &&
                (pending_results.size() == 0 ||
                 pending_results[$].kind != stim_rows[i].kind ||
                 pending_results[$].last_of_message != stim_rows[i].last)) begin
                $error("row %0d: predicted kind/last differ from table", i);
                fails++;
            end
        end

        foreach (reg_sets[k]) begin
            drain_results();
            set_config(reg_sets[k].csz, reg_sets[k].aw, reg_sets[k].ml);
            calm = (k == 3);
            start = bytes_sent;
            while (bytes_sent - start < PHASE_LEN) send_chunk(1'b0);
            while (any_open()) send_chunk(1'b1);
        end
        calm = 1'b0;

        // one protocol error ends the run; the block stays halted after it
        drain_results();
        set_config(17'd4, ACK_WINDOW_RST, 24'd16);
        pick = $urandom_range(1, 4);
        case (pick)
            1: begin
                // new header while stream 5 is mid-message
                send_hdr0(6'd5, 24'd10);
                repeat (4) send_byte(8'($urandom));
                send_byte({2'($urandom_range(0, 2)), 6'd5});
            end
            2: send_byte({2'($urandom_range(1, 3)), 6'd63});   // stream never opened
            3: send_hdr0(6'd6, 24'd17);                         // longer than limit
            default: begin
                // two- or three-byte id lands past the table
                if ($urandom_range(0, 1) == 0) begin
                    send_byte({2'($urandom), 6'd0});
                end else begin
                    send_byte({2'($urandom), 6'd1});
                    send_byte(8'($urandom));
                end
                send_byte(8'($urandom));
            end
        endcase
        repeat (6) send_byte(8'($urandom));   // ignored while halted

        drain_results();
        if (fails == 0)
            $display("PASS chunk_stream_deframer_unit");
        else
            $display("FAIL chunk_stream_deframer_unit");
        $finish;
    end

endmodule
